FILE: sv/srps_pkg.sv
// ----------------------------------------------------------------------------
// Sample rate prescaler select package
// Shared widths, reset values and defaults for the prescaler search block.
// ----------------------------------------------------------------------------
package srps_pkg;

  localparam int CLK_W   = 30;  // audio clock frequency in hertz
  localparam int RATE_W  = 20;  // sample rate in hertz
  localparam int PVAL_W  = 6;   // prescaler value field
  localparam int PWORD_W = 16;  // prescaler register word

  localparam int FS_RATIO_DEFAULT    = 384;
  localparam int MAX_DIVISOR_DEFAULT = 32;

  localparam int ENABLE_BIT     = 15;
  localparam int PRESCALE_SHIFT = 8;

  localparam logic [CLK_W-1:0]  RESET_CLOCK = CLK_W'(16934400);
  localparam logic [RATE_W-1:0] RESET_RATE  = RATE_W'(44100);

endpackage

FILE: sv/sample_rate_prescaler_select_top.sv
// ----------------------------------------------------------------------------
// Sample rate prescaler select
// A single serial divider is shared by all steps; a rejected request takes one
// division, an accepted one up to MAX_DIVISOR + 2 divisions.
// Requests are taken one at a time; the next is taken once the result is
// registered. Reset restores the 16934400 Hz clock and a 44100 Hz rate.
// ----------------------------------------------------------------------------
module sample_rate_prescaler_select_top #(
  parameter int FS_RATIO    = srps_pkg::FS_RATIO_DEFAULT,
  parameter int MAX_DIVISOR = srps_pkg::MAX_DIVISOR_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [srps_pkg::CLK_W-1:0]   cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [srps_pkg::RATE_W-1:0]  requested_rate,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         accepted,
  output logic [srps_pkg::PVAL_W-1:0]  prescaler_value,
  output logic [srps_pkg::PWORD_W-1:0] prescaler_word,
  output logic [srps_pkg::RATE_W-1:0]  applied_rate
);
  import srps_pkg::*;

  localparam int D_W     = $clog2(MAX_DIVISOR + 2);
  localparam int FS_W    = $clog2(FS_RATIO + 1);
  localparam int DIV_W   = (FS_W > D_W) ? FS_W : D_W;
  localparam logic [D_W-1:0] D_LAST = D_W'(MAX_DIVISOR - 1);
  localparam logic [D_W-1:0] D_MAX  = D_W'(MAX_DIVISOR);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_BASE   = 6'b000010,
    S_SEARCH = 6'b000100,
    S_UPPER  = 6'b001000,
    S_LOWER  = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  state_t            state;
  logic [CLK_W-1:0]  clk_hz;
  logic [RATE_W-1:0] current_rate;
  logic [RATE_W-1:0] req;
  logic [D_W-1:0]    d;
  logic [D_W-1:0]    choice;
  logic [CLK_W-1:0]  e1;
  logic              acc;

  logic              div_go;
  logic [CLK_W-1:0]  div_dividend;
  logic [DIV_W-1:0]  div_divisor;
  logic              div_done;
  logic [CLK_W-1:0]  div_q;

  logic [CLK_W-1:0]  q_err;
  logic              q_below;
  logic [D_W-1:0]    p;
  logic              out_free;

  srps_div #(
    .DIV_W(DIV_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (div_go),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    q_below = (div_q < CLK_W'(req));
    q_err   = q_below ? (CLK_W'(req) - div_q) : (div_q - CLK_W'(req));
    p       = (choice == '0) ? '0 : (choice - D_W'(1));
    out_free = !out_valid || out_ready;
  end

  assign cfg_ready = !rst;
  assign in_ready  = (state == S_IDLE) && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      clk_hz <= RESET_CLOCK;
    end else if (cfg_valid) begin
      clk_hz <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      div_go       <= 1'b0;
      out_valid    <= 1'b0;
      current_rate <= RESET_RATE;
    end else begin
      div_go <= 1'b0;
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            req          <= requested_rate;
            div_dividend <= clk_hz;
            div_divisor  <= DIV_W'(FS_RATIO);
            div_go       <= 1'b1;
            state        <= S_BASE;
          end
        end
        S_BASE: begin
          if (div_done) begin
            if (CLK_W'(req) > (div_q >> 1)) begin
              acc   <= 1'b0;
              state <= S_DONE;
            end else begin
              d            <= D_W'(1);
              div_dividend <= div_q;
              div_divisor  <= DIV_W'(1);
              div_go       <= 1'b1;
              state        <= S_SEARCH;
            end
          end
        end
        S_SEARCH: begin
          if (div_done) begin
            e1     <= q_err;
            div_go <= 1'b1;
            if (q_below) begin
              div_divisor <= DIV_W'(d + D_W'(1));
              state       <= S_UPPER;
            end else if (d == D_LAST) begin
              // No divisor went below the request; the middle quotient stays
              // that of the last divisor tried.
              d           <= D_MAX;
              div_divisor <= DIV_W'(D_MAX + D_W'(1));
              state       <= S_UPPER;
            end else begin
              d           <= d + D_W'(1);
              div_divisor <= DIV_W'(d + D_W'(1));
            end
          end
        end
        S_UPPER: begin
          if (div_done) begin
            choice <= (q_err < e1) ? (d + D_W'(1)) : d;
            if (d > D_W'(1)) begin
              div_divisor <= DIV_W'(d - D_W'(1));
              div_go      <= 1'b1;
              state       <= S_LOWER;
            end else begin
              acc   <= 1'b1;
              state <= S_DONE;
            end
          end
        end
        S_LOWER: begin
          if (div_done) begin
            // The lower divisor is weighed against the middle one and wins last.
            if (q_err < e1) begin
              choice <= d - D_W'(1);
            end
            acc   <= 1'b1;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            if (acc) begin
              current_rate <= req;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      accepted <= acc;
      if (acc) begin
        prescaler_value <= PVAL_W'(p);
        prescaler_word  <= (PWORD_W'(p) << PRESCALE_SHIFT) | (PWORD_W'(1) << ENABLE_BIT);
        applied_rate    <= req;
      end else begin
        prescaler_value <= '0;
        prescaler_word  <= '0;
        applied_rate    <= current_rate;
      end
    end
  end

endmodule

FILE: sv/srps_div.sv
// ----------------------------------------------------------------------------
// Serial divider
// Restoring division, one quotient bit per cycle, for a full-width dividend
// and a narrow divisor. A go pulse loads the operands; done pulses once the
// quotient is complete and the quotient then holds until the next go.
// ----------------------------------------------------------------------------
module srps_div #(
  parameter int DIV_W = 9
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      go,
  input  logic [srps_pkg::CLK_W-1:0] dividend,
  input  logic [DIV_W-1:0]          divisor,
  output logic                      done,
  output logic [srps_pkg::CLK_W-1:0] quotient
);
  import srps_pkg::*;

  localparam int CNT_W = $clog2(CLK_W + 1);

  logic [CLK_W-1:0] quo;
  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] dvs;
  logic [CNT_W-1:0] count;
  logic             busy;

  logic [DIV_W:0]   trial;
  logic [DIV_W:0]   diff;
  logic             ge;

  // The dividend shifts out of the top of quo while quotient bits shift in.
  always_comb begin
    trial = {rem, quo[CLK_W-1]};
    ge    = (trial >= {1'b0, dvs});
    diff  = trial - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy  <= 1'b1;
        count <= CNT_W'(CLK_W);
      end else if (busy) begin
        count <= count - CNT_W'(1);
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[CLK_W-2:0], ge};
      rem <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
    end
  end

  assign quotient = quo;

endmodule
